@@ rtl/core/br1pd_pkg.sv @@
// Shared types and constants for the ByteRun1 planar body decoder.
package br1pd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANES = 2'd3;

    localparam logic [7:0]  MODE_RESET   = 8'd1;
    localparam logic [12:0] WIDTH_RESET  = 13'd320;
    localparam logic [12:0] HEIGHT_RESET = 13'd200;
    localparam logic [3:0]  PLANES_RESET = 4'd5;

    localparam logic [7:0] CMP_NONE     = 8'd0;
    localparam logic [7:0] CMP_BYTERUN1 = 8'd1;

    localparam logic [7:0] CTRL_NOP = 8'h80;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_CHUNK   = 2'd1;
    localparam logic [1:0] ERR_OVERRUN = 2'd2;
    localparam logic [1:0] ERR_MODE    = 2'd3;

    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_LIT  = 2'd1,
        PH_RUN  = 2'd2
    } phase_t;

    typedef struct packed {
        logic accept;
        logic scan_step;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic run_item;
        logic scan_final;
        logic emit_final;
    } sts_t;

endpackage

@@ rtl/core/br1pd_ctrl.sv @@
// Controller state machine: handshakes, run scan and run emit sequencing.
module br1pd_ctrl
    import br1pd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_stall,
    input  sts_t sts,
    output logic in_stall,
    output logic out_valid,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   load_out;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = !out_free;
                if (in_valid && out_free)
                begin
                    cmd.accept = 1'b1;
                    if (sts.run_item)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        load_out = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_final)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_step = 1'b1;
                    load_out      = 1'b1;
                    if (sts.emit_final)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/br1pd_dp.sv @@
// Datapath: configuration, parse state, position counters and result register.
module br1pd_dp
    import br1pd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_PLANES = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]             code_byte,
    input  logic                   chunk_end,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic [7:0]             first_byte,
    output logic [7:0]             second_byte,
    output logic [1:0]             pair_count,
    output logic [11:0]            out_row,
    output logic [2:0]             out_plane,
    output logic [8:0]             out_column,
    output logic                   run_last,
    output logic                   picture_done,
    output logic [1:0]             error_code
);

    localparam int RB_MAX = ((MAX_WIDTH + 15) / 16) * 2;
    localparam int CW     = $clog2(RB_MAX + 2);
    localparam int RW     = $clog2(MAX_HEIGHT + 65);
    localparam int PW     = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PCW    = $clog2(MAX_PLANES + 1);
    localparam int KW     = ((CW > 8) ? CW : 8) + 1;

    // configuration
    logic [7:0]  mode_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [3:0]  planes_reg;

    // parse and position state
    phase_t        phase_reg, phase_next;
    logic [7:0]    lit_reg, lit_next;
    logic [7:0]    runlen_reg, runlen_next;
    logic [CW-1:0] col_reg, col_next;
    logic [PW-1:0] plane_reg, plane_next;
    logic [RW-1:0] row_reg, row_next;
    logic [1:0]    err_reg, err_next;

    // run sequencing
    logic [CW-1:0] snap_col_reg, snap_col_next;
    logic [PW-1:0] snap_plane_reg, snap_plane_next;
    logic [RW-1:0] snap_row_reg, snap_row_next;
    logic [7:0]    scan_left_reg, scan_left_next;
    logic [7:0]    emit_left_reg, emit_left_next;
    logic [7:0]    run_byte_reg, run_byte_next;
    logic          run_end_reg, run_end_next;
    logic          fin_done_reg, fin_done_next;

    // result register
    logic [7:0]  first_reg, first_next;
    logic [7:0]  second_reg, second_next;
    logic [1:0]  count_reg, count_next;
    logic [11:0] orow_reg, orow_next;
    logic [2:0]  oplane_reg, oplane_next;
    logic [8:0]  ocol_reg, ocol_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;
    logic [1:0]  oerr_reg, oerr_next;

    // clamped geometry
    logic [10:0]    rb_full;
    logic [CW-1:0]  rb;
    logic [RW-1:0]  rows;
    logic [PCW-1:0] planes;
    logic           cfg_zero;

    // shared advance unit
    logic [CW-1:0] adv_col_in, col_sum, adv_col;
    logic [PW-1:0] adv_plane_in, adv_plane;
    logic [RW-1:0] adv_row_in, adv_row;
    logic [1:0]    adv_n;
    logic [PW:0]   plane_inc;
    logic          col_wrap, plane_wrap;

    logic          done_now, done_adv, s_done, pos_moved;
    logic          active, is_m0, is_m1, data_item, ctrl_lit, overrun, load_out;
    logic [7:0]    lit_cnt, rep_cnt, ctrl_cnt, lit_dec;
    logic [8:0]    rep_diff;
    logic [CW-1:0] room;
    logic [1:0]    scan_c, emit_c;

    assign rb_full = 11'((({1'b0, width_reg} + 14'd15) >> 4) << 1);
    assign rb      = (32'(rb_full) > RB_MAX) ? CW'(RB_MAX) : CW'(rb_full);
    assign rows    = (32'(height_reg) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_reg);
    assign planes  = (32'(planes_reg) > MAX_PLANES) ? PCW'(MAX_PLANES) : PCW'(planes_reg);
    assign cfg_zero = (rb == '0) || (planes == '0) || (rows == '0);

    assign scan_c = (scan_left_reg >= 8'd2) ? 2'd2 : scan_left_reg[1:0];
    assign emit_c = (emit_left_reg >= 8'd2) ? 2'd2 : emit_left_reg[1:0];

    always_comb
    begin
        adv_col_in   = cmd.emit_step ? snap_col_reg : col_reg;
        adv_plane_in = cmd.emit_step ? snap_plane_reg : plane_reg;
        adv_row_in   = cmd.emit_step ? snap_row_reg : row_reg;
        if (cmd.scan_step)
        begin
            adv_n = scan_c;
        end
        else if (cmd.emit_step)
        begin
            adv_n = emit_c;
        end
        else
        begin
            adv_n = 2'd1;
        end
        col_sum    = adv_col_in + CW'(adv_n);
        col_wrap   = col_sum >= rb;
        plane_inc  = {1'b0, adv_plane_in} + (PW+1)'(1);
        plane_wrap = plane_inc >= (PW+1)'(planes);
        adv_col    = col_wrap ? '0 : col_sum;
        if (!col_wrap)
        begin
            adv_plane = adv_plane_in;
            adv_row   = adv_row_in;
        end
        else if (plane_wrap)
        begin
            adv_plane = '0;
            adv_row   = adv_row_in + RW'(1);
        end
        else
        begin
            adv_plane = PW'(plane_inc);
            adv_row   = adv_row_in;
        end
    end

    assign done_now = cfg_zero || (row_reg >= rows);
    assign done_adv = cfg_zero || (adv_row >= rows);

    assign active    = (err_reg == ERR_NONE) && !done_now;
    assign is_m0     = mode_reg == CMP_NONE;
    assign is_m1     = mode_reg == CMP_BYTERUN1;
    assign data_item = active && (is_m0 || (is_m1 && phase_reg == PH_LIT));

    assign ctrl_lit = !code_byte[7];
    assign lit_cnt  = code_byte + 8'd1;
    assign rep_diff = 9'd257 - {1'b0, code_byte};
    assign rep_cnt  = rep_diff[7:0];
    assign ctrl_cnt = ctrl_lit ? lit_cnt : rep_cnt;
    assign room     = (col_reg < rb) ? (rb - col_reg) : '0;
    assign overrun  = KW'(ctrl_cnt) > KW'(room);
    assign lit_dec  = lit_reg - 8'd1;

    assign sts.run_item   = active && is_m1 && (phase_reg == PH_RUN);
    assign sts.scan_final = scan_left_reg <= 8'd2;
    assign sts.emit_final = emit_left_reg <= 8'd2;

    assign load_out = (cmd.accept && !sts.run_item) || cmd.emit_step;

    always_comb
    begin
        phase_next      = phase_reg;
        lit_next        = lit_reg;
        runlen_next     = runlen_reg;
        col_next        = col_reg;
        plane_next      = plane_reg;
        row_next        = row_reg;
        err_next        = err_reg;
        snap_col_next   = snap_col_reg;
        snap_plane_next = snap_plane_reg;
        snap_row_next   = snap_row_reg;
        scan_left_next  = scan_left_reg;
        emit_left_next  = emit_left_reg;
        run_byte_next   = run_byte_reg;
        run_end_next    = run_end_reg;
        fin_done_next   = fin_done_reg;
        pos_moved       = 1'b0;
        s_done          = done_now;

        first_next  = 8'd0;
        second_next = 8'd0;
        count_next  = 2'd0;
        orow_next   = 12'(row_reg);
        oplane_next = 3'(plane_reg);
        ocol_next   = 9'(col_reg);
        last_next   = 1'b1;
        done_next   = done_now;
        oerr_next   = err_reg;

        if (cmd.accept && sts.run_item)
        begin
            phase_next      = PH_CTRL;
            runlen_next     = 8'd0;
            snap_col_next   = col_reg;
            snap_plane_next = plane_reg;
            snap_row_next   = row_reg;
            scan_left_next  = runlen_reg;
            emit_left_next  = runlen_reg;
            run_byte_next   = code_byte;
            run_end_next    = chunk_end;
        end
        else if (cmd.accept)
        begin
            if (active)
            begin
                if (is_m0)
                begin
                    pos_moved = 1'b1;
                end
                else if (is_m1)
                begin
                    case (phase_reg)
                        PH_LIT:
                        begin
                            pos_moved = 1'b1;
                            lit_next  = lit_dec;
                            if (lit_dec == 8'd0)
                            begin
                                phase_next = PH_CTRL;
                            end
                        end
                        PH_CTRL:
                        begin
                            if (code_byte != CTRL_NOP)
                            begin
                                if (overrun)
                                begin
                                    err_next = ERR_OVERRUN;
                                end
                                else if (ctrl_lit)
                                begin
                                    lit_next   = ctrl_cnt;
                                    phase_next = PH_LIT;
                                end
                                else
                                begin
                                    runlen_next = ctrl_cnt;
                                    phase_next  = PH_RUN;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_CTRL;
                        end
                    endcase
                end
                else
                begin
                    err_next = ERR_MODE;
                end
                if (pos_moved)
                begin
                    col_next   = adv_col;
                    plane_next = adv_plane;
                    row_next   = adv_row;
                    s_done     = done_adv;
                end
                if (chunk_end && (err_next == ERR_NONE) && !s_done)
                begin
                    err_next = ERR_CHUNK;
                end
            end
            done_next = s_done;
            oerr_next = err_next;
            if (data_item)
            begin
                first_next = code_byte;
                count_next = 2'd1;
            end
            else if (s_done)
            begin
                orow_next   = 12'd0;
                oplane_next = 3'd0;
                ocol_next   = 9'd0;
            end
            else
            begin
                orow_next   = 12'(row_next);
                oplane_next = 3'(plane_next);
                ocol_next   = 9'(col_next);
            end
        end
        else if (cmd.scan_step)
        begin
            col_next       = adv_col;
            plane_next     = adv_plane;
            row_next       = adv_row;
            scan_left_next = scan_left_reg - 8'(scan_c);
            if (sts.scan_final)
            begin
                fin_done_next = done_adv;
                if (run_end_reg && (err_reg == ERR_NONE) && !done_adv)
                begin
                    err_next = ERR_CHUNK;
                end
            end
        end
        else if (cmd.emit_step)
        begin
            first_next      = run_byte_reg;
            second_next     = (emit_c == 2'd2) ? run_byte_reg : 8'd0;
            count_next      = emit_c;
            orow_next       = 12'(snap_row_reg);
            oplane_next     = 3'(snap_plane_reg);
            ocol_next       = 9'(snap_col_reg);
            last_next       = sts.emit_final;
            done_next       = fin_done_reg;
            oerr_next       = err_reg;
            snap_col_next   = adv_col;
            snap_plane_next = adv_plane;
            snap_row_next   = adv_row;
            emit_left_next  = emit_left_reg - 8'(emit_c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            planes_reg    <= PLANES_RESET;
            phase_reg     <= PH_CTRL;
            lit_reg       <= 8'd0;
            runlen_reg    <= 8'd0;
            col_reg       <= '0;
            plane_reg     <= '0;
            row_reg       <= '0;
            err_reg       <= ERR_NONE;
            scan_left_reg <= 8'd0;
            emit_left_reg <= 8'd0;
            run_end_reg   <= 1'b0;
            fin_done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[7:0];
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_PLANES: planes_reg <= cfg_data[3:0];
                    default:    mode_reg   <= mode_reg;
                endcase
            end
            phase_reg     <= phase_next;
            lit_reg       <= lit_next;
            runlen_reg    <= runlen_next;
            col_reg       <= col_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            err_reg       <= err_next;
            scan_left_reg <= scan_left_next;
            emit_left_reg <= emit_left_next;
            run_end_reg   <= run_end_next;
            fin_done_reg  <= fin_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        snap_col_reg   <= snap_col_next;
        snap_plane_reg <= snap_plane_next;
        snap_row_reg   <= snap_row_next;
        run_byte_reg   <= run_byte_next;
        if (load_out)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
            orow_reg   <= orow_next;
            oplane_reg <= oplane_next;
            ocol_reg   <= ocol_next;
            last_reg   <= last_next;
            done_reg   <= done_next;
            oerr_reg   <= oerr_next;
        end
    end

    assign first_byte   = first_reg;
    assign second_byte  = second_reg;
    assign pair_count   = count_reg;
    assign out_row      = orow_reg;
    assign out_plane    = oplane_reg;
    assign out_column   = ocol_reg;
    assign run_last     = last_reg;
    assign picture_done = done_reg;
    assign error_code   = oerr_reg;

endmodule

@@ rtl/core/byterun1_planar_body_decoder_core.sv @@
// Top level of the ByteRun1 planar body decoder.
// Usage:
//   Input channel (in_valid/in_stall, code_byte, chunk_end) takes one body byte
//   per transaction; chunk_end marks the last byte of the body chunk.
//   Output channel (out_valid/out_stall) carries results: up to two decoded
//   bytes with their row, plane and column, plus sticky status.
//   Configuration registers (mode, width, height, planes) are written through
//   cfg_we/cfg_index/cfg_data while the decoder is idle.
// Timing:
//   Literal, uncompressed, control and ignored bytes give one result, held in
//   the output register in the cycle after the input transaction; such bytes are
//   taken one per cycle while the output is not stalled.
//   A repeat byte of n bytes gives ceil(n/2) results: the position counters
//   are first stepped once per pair to settle the final status, then one
//   pair leaves per cycle while the output is not stalled, with in_stall
//   high meanwhile.
// Reset: parse state, positions, sticky error and registers return to their
//   defaults; no clearing pass is needed.
// Stall: a stalled result holds its payload; the decoder stops taking input
//   until the output register can be loaded again.
module byterun1_planar_body_decoder_core
    import br1pd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_PLANES = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             code_byte,
    input  logic                   chunk_end,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             first_byte,
    output logic [7:0]             second_byte,
    output logic [1:0]             pair_count,
    output logic [11:0]            out_row,
    output logic [2:0]             out_plane,
    output logic [8:0]             out_column,
    output logic                   run_last,
    output logic                   picture_done,
    output logic [1:0]             error_code
);

    cmd_t cmd;
    sts_t sts;

    br1pd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    br1pd_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_PLANES (MAX_PLANES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .code_byte    (code_byte),
        .chunk_end    (chunk_end),
        .cmd          (cmd),
        .sts          (sts),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .pair_count   (pair_count),
        .out_row      (out_row),
        .out_plane    (out_plane),
        .out_column   (out_column),
        .run_last     (run_last),
        .picture_done (picture_done),
        .error_code   (error_code)
    );

endmodule

@@ rtl/core/br1pd_chk.sv @@
// Port-level assertion checker for the decoder, bound to the top level.
module br1pd_chk
    import br1pd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] first_byte,
    input logic [7:0] second_byte,
    input logic [1:0] pair_count,
    input logic       run_last,
    input logic [1:0] error_code
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pair_count != 2'd3)
        else $error("pair count out of range");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_count == 2'd0 |->
            first_byte == 8'd0 && second_byte == 8'd0 && run_last)
        else $error("malformed status result");

    a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_count != 2'd2 |-> second_byte == 8'd0)
        else $error("second byte set on a short result");

    a_data_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_count != 2'd0 |->
            error_code == ERR_NONE || error_code == ERR_CHUNK)
        else $error("decoded bytes carry a decode error");

endmodule

bind byterun1_planar_body_decoder_core br1pd_chk u_br1pd_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .first_byte  (first_byte),
    .second_byte (second_byte),
    .pair_count  (pair_count),
    .run_last    (run_last),
    .error_code  (error_code)
);

@@ sim/tb_byterun1_planar_body_decoder_core.sv @@
// Self-checking testbench for the ByteRun1 planar body decoder core.
module tb_byterun1_planar_body_decoder_core;
    import br1pd_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int RANDOM_ITEMS = 360;
    localparam int LIM_WIDTH    = 4096;
    localparam int LIM_HEIGHT   = 4096;
    localparam int LIM_PLANES   = 8;

    typedef struct packed {
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [1:0]  count;
        logic [11:0] row;
        logic [2:0]  plane;
        logic [8:0]  col;
        logic        is_last;
        logic        done;
        logic [1:0]  err;
    } pair_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             code_byte = '0;
    logic                   chunk_end = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b1;
    logic [7:0]             first_byte;
    logic [7:0]             second_byte;
    logic [1:0]             pair_count;
    logic [11:0]            out_row;
    logic [2:0]             out_plane;
    logic [8:0]             out_column;
    logic                   run_last;
    logic                   picture_done;
    logic [1:0]             error_code;

    byterun1_planar_body_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .code_byte    (code_byte),
        .chunk_end    (chunk_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .pair_count   (pair_count),
        .out_row      (out_row),
        .out_plane    (out_plane),
        .out_column   (out_column),
        .run_last     (run_last),
        .picture_done (picture_done),
        .error_code   (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // decoder shadow state
    logic [7:0]  reg_mode   = MODE_RESET;
    logic [12:0] reg_width  = WIDTH_RESET;
    logic [12:0] reg_height = HEIGHT_RESET;
    logic [3:0]  reg_planes = PLANES_RESET;
    phase_t      phase      = PH_CTRL;
    int          lit_left   = 0;
    int          run_len    = 0;
    int          cur_col    = 0;
    int          cur_plane  = 0;
    int          cur_row    = 0;
    logic [1:0]  sticky     = ERR_NONE;

    pair_t pending_pairs[$];
    int    mismatches  = 0;
    int    live_items  = 0;
    int    cycle_count = 0;
    bit    tx_idle_on  = 1'b1;
    bit    rx_idle_on  = 1'b1;
    bit    hold_req    = 1'b0;

    function automatic int row_len();
        int w;
        w = (reg_width > LIM_WIDTH) ? LIM_WIDTH : int'(reg_width);
        return ((w + 15) >> 4) * 2;
    endfunction

    function automatic int plane_lim();
        return (reg_planes > LIM_PLANES) ? LIM_PLANES : int'(reg_planes);
    endfunction

    function automatic int row_lim();
        return (reg_height > LIM_HEIGHT) ? LIM_HEIGHT : int'(reg_height);
    endfunction

    function automatic bit pic_done();
        return row_len() == 0 || plane_lim() == 0 || row_lim() == 0 || cur_row >= row_lim();
    endfunction

    function automatic int room();
        return (cur_col < row_len()) ? row_len() - cur_col : 0;
    endfunction

    function automatic bit ends_picture(int n);
        return cur_col + n >= row_len() && cur_plane + 1 >= plane_lim() &&
               cur_row + 1 >= row_lim();
    endfunction

    function automatic void move_on(int n);
        cur_col += n;
        if (cur_col >= row_len())
        begin
            cur_col = 0;
            cur_plane++;
            if (cur_plane >= plane_lim())
            begin
                cur_plane = 0;
                cur_row++;
            end
        end
    endfunction

    function automatic pair_t make_pair(logic [7:0] b0, logic [7:0] b1, int cnt);
        pair_t p;
        bit    blank;
        blank = pic_done() && cnt == 0;
        p.b0 = b0;
        p.b1 = b1;
        p.count = 2'(cnt);
        p.row = blank ? '0 : 12'(cur_row);
        p.plane = blank ? '0 : 3'(cur_plane);
        p.col = blank ? '0 : 9'(cur_col);
        p.is_last = 1'b0;
        p.done = 1'b0;
        p.err = ERR_NONE;
        return p;
    endfunction

    function automatic void decode_byte(logic [7:0] code, logic is_end);
        pair_t step_q[$];
        int    left;
        int    c;
        int    cnt;
        if (sticky == ERR_NONE && !pic_done())
        begin
            if (reg_mode == CMP_NONE)
            begin
                step_q.push_back(make_pair(code, 8'h00, 1));
                move_on(1);
            end
            else if (reg_mode == CMP_BYTERUN1)
            begin
                case (phase)
                    PH_LIT:
                    begin
                        step_q.push_back(make_pair(code, 8'h00, 1));
                        move_on(1);
                        lit_left--;
                        if (lit_left == 0)
                            phase = PH_CTRL;
                    end
                    PH_RUN:
                    begin
                        left = run_len;
                        while (left > 0)
                        begin
                            c = (left < 2) ? left : 2;
                            step_q.push_back(make_pair(code, (c == 2) ? code : 8'h00, c));
                            move_on(c);
                            left -= c;
                        end
                        run_len = 0;
                        phase = PH_CTRL;
                    end
                    default:
                    begin
                        if (code < 8'd128)
                        begin
                            cnt = int'(code) + 1;
                            if (cnt > room())
                                sticky = ERR_OVERRUN;
                            else
                            begin
                                lit_left = cnt;
                                phase = PH_LIT;
                            end
                        end
                        else if (code != CTRL_NOP)
                        begin
                            cnt = 257 - int'(code);
                            if (cnt > room())
                                sticky = ERR_OVERRUN;
                            else
                            begin
                                run_len = cnt;
                                phase = PH_RUN;
                            end
                        end
                    end
                endcase
            end
            else
                sticky = ERR_MODE;
            if (is_end && sticky == ERR_NONE && !pic_done())
                sticky = ERR_CHUNK;
        end
        if (step_q.size() == 0)
            step_q.push_back(make_pair(8'h00, 8'h00, 0));
        foreach (step_q[i])
        begin
            step_q[i].is_last = (i == step_q.size() - 1);
            step_q[i].done = pic_done();
            step_q[i].err = sticky;
            pending_pairs.push_back(step_q[i]);
        end
    endfunction

    task automatic send_byte(logic [7:0] code, logic is_end);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_idle_on = !tx_idle_on;
        gap = (tx_idle_on && $urandom_range(0, 1) == 1) ? $urandom_range(1, 16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        code_byte <= code;
        chunk_end <= is_end;
        do @(posedge clk); while (in_stall);
        if (sticky == ERR_NONE && !pic_done())
            live_items++;
        decode_byte(code, is_end);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MODE:   reg_mode = val[7:0];
            REG_WIDTH:  reg_width = val;
            REG_HEIGHT: reg_height = val;
            default:    reg_planes = val[3:0];
        endcase
    endtask

    // picture continues from the current row; height covers n_rows more
    task automatic start_picture(logic [7:0] mode, int width, int planes, int n_rows);
        pause_until_drained();
        write_reg(REG_MODE, 13'(mode));
        write_reg(REG_WIDTH, 13'(width));
        write_reg(REG_PLANES, 13'(planes));
        write_reg(REG_HEIGHT, 13'(cur_row + n_rows));
    endtask

    function automatic logic end_flag(int n, bit force_end);
        return ends_picture(n) && (force_end || $urandom_range(0, 1) == 1);
    endfunction

    function automatic int pick_count(int lo, int hi);
        int top;
        top = (hi > 128) ? 128 : hi;
        if ($urandom_range(0, 3) == 0)
            return top;
        return $urandom_range(lo, (top < 16) ? top : 16);
    endfunction

    // well-formed body bytes until every row and plane is filled
    task automatic fill_picture(bit force_end);
        int cnt;
        int rm;
        while (!pic_done())
        begin
            if (reg_mode == CMP_NONE)
                send_byte(8'($urandom_range(0, 255)), end_flag(1, force_end));
            else
            begin
                rm = room();
                if ($urandom_range(0, 9) == 0)
                    send_byte(CTRL_NOP, 1'b0);
                else if (rm < 2 || $urandom_range(0, 1) == 1)
                begin
                    cnt = pick_count(1, rm);
                    send_byte(8'(cnt - 1), 1'b0);
                    repeat (cnt) send_byte(8'($urandom_range(0, 255)), end_flag(1, force_end));
                end
                else
                begin
                    cnt = pick_count(2, rm);
                    send_byte(8'(257 - cnt), 1'b0);
                    send_byte(8'($urandom_range(0, 255)), end_flag(cnt, force_end));
                end
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_byte(CTRL_NOP, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hFD, 1'b0);
        send_byte(8'hC3, 1'b0);
    endtask

    task automatic test_long_runs();
        pause_until_drained();
        write_reg(REG_WIDTH, 13'd4096);
        write_reg(REG_PLANES, 13'd1);
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_uncompressed();
        pause_until_drained();
        write_reg(REG_MODE, 13'(CMP_NONE));
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CTRL_NOP, 1'b0);
        send_byte(8'h7F, 1'b0);
        // shrink the row under the current column: byte lands there, then wrap
        pause_until_drained();
        write_reg(REG_WIDTH, 13'd1);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_picture_end();
        start_picture(CMP_BYTERUN1, 1, 2, 1);
        fill_picture(1'b1);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hC3, 1'b1);
        pause_until_drained();
        write_reg(REG_MODE, 13'hFF);
        send_byte(8'h11, 1'b1);
    endtask

    task automatic test_output_backpressure();
        start_picture(CMP_BYTERUN1, 640, 1, 1);
        tx_idle_on = 1'b0;
        hold_req = 1'b1;
        send_byte(8'd31, 1'b0);
        repeat (32) send_byte(8'($urandom_range(0, 255)), 1'b0);
        fill_picture(1'b0);
    endtask

    task automatic test_random_pictures();
        int goal;
        int sel;
        logic [7:0] mode;
        goal = live_items + RANDOM_ITEMS;
        while (live_items < goal)
        begin
            sel = $urandom_range(0, 11);
            if (sel == 0)
                start_picture(CMP_BYTERUN1,
                              $urandom_range(0, 1) ? 4096 : $urandom_range(1, 4096), 1, 1);
            else
            begin
                mode = (sel < 4) ? CMP_NONE : CMP_BYTERUN1;
                start_picture(mode, $urandom_range(1, 80),
                              (mode == CMP_NONE) ? $urandom_range(1, 3) : $urandom_range(1, 8),
                              $urandom_range(1, 2));
            end
            fill_picture(1'b0);
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                1:
                begin
                    pause_until_drained();
                    write_reg(REG_MODE, 13'($urandom_range(2, 255)));
                    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                default: ;
            endcase
        end
    endtask

    // only one error can be raised per reset, so its kind is drawn
    task automatic test_sticky_error();
        start_picture(CMP_BYTERUN1, 16, 8, 4096 - cur_row);
        case ($urandom_range(0, 2))
            0: send_byte($urandom_range(0, 1) ? 8'h02 : 8'hFE, 1'($urandom_range(0, 1)));
            1:
            begin
                send_byte(8'h01, 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
            begin
                write_reg(REG_MODE, 13'($urandom_range(2, 255)));
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        endcase
        repeat (3) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin : result_sink
        int n;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 39) == 0)
                rx_idle_on = !rx_idle_on;
            n = (rx_idle_on && $urandom_range(0, 1) == 1) ? $urandom_range(1, 16) : 0;
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        pair_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pairs.size() == 0)
            begin
                $error("unexpected transaction: first_byte %0d, pair_count %0d",
                       first_byte, pair_count);
                mismatches++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                check_field("first_byte", 16'(want.b0), 16'(first_byte));
                check_field("second_byte", 16'(want.b1), 16'(second_byte));
                check_field("pair_count", 16'(want.count), 16'(pair_count));
                check_field("out_row", 16'(want.row), 16'(out_row));
                check_field("out_plane", 16'(want.plane), 16'(out_plane));
                check_field("out_column", 16'(want.col), 16'(out_column));
                check_field("run_last", 16'(want.is_last), 16'(run_last));
                check_field("picture_done", 16'(want.done), 16'(picture_done));
                check_field("error_code", 16'(want.err), 16'(error_code));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_long_runs();
        test_uncompressed();
        test_picture_end();
        test_output_backpressure();
        test_random_pictures();
        test_sticky_error();
        pause_until_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/br1pd_pkg.sv
rtl/core/br1pd_ctrl.sv
rtl/core/br1pd_dp.sv
rtl/core/byterun1_planar_body_decoder_core.sv
rtl/core/br1pd_chk.sv
sim/tb_byterun1_planar_body_decoder_core.sv
